// ===== hdl/quadratic_thrust_power_mapper_top_defines.svh =====
// Assertion macros for the quadratic thrust/power mapper.
// Included by the top level; depends on nothing else.
`ifndef QUADRATIC_THRUST_POWER_MAPPER_TOP_DEFINES_SVH
`define QUADRATIC_THRUST_POWER_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QTPM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qtpm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define QTPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qtpm assertion failed");

`endif

// ===== hdl/qtpm_pkg.sv =====
// Types and constants for the quadratic thrust/power mapper.
// No dependencies; used by quadratic_thrust_power_mapper_top.
package qtpm_pkg;

   // Request codes
   typedef enum logic [1:0] {
      OP_THRUST_TO_POWER = 2'd0,
      OP_POWER_TO_THRUST = 2'd1,
      OP_SCALE           = 2'd2,
      OP_UNUSED          = 2'd3
   } qtpm_op_type;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_CONSTANT = 2'd0;
   localparam logic [1:0] REG_LINEAR   = 2'd1;
   localparam logic [1:0] REG_SQUARE   = 2'd2;

   localparam logic signed [15:0] SQUARE_RESET = 16'sd256;

   // Power threshold 0.01: n*6400 < 32768*q
   localparam logic signed [18:0] THRESH_MUL = 19'sd6400;

   // Iteration counts minus one
   localparam logic [4:0] SQRT_LAST = 5'd24;
   localparam logic [4:0] DIV_LAST  = 5'd15;

   // Q1.15 plus and minus 1.0 on 17 bits
   localparam logic [16:0] RESULT_ONE       = 17'h08000;
   localparam logic [16:0] RESULT_MINUS_ONE = 17'h18000;
   localparam logic [15:0] QUOT_CAP         = 16'h8000;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] operand_in;
   } qtpm_request_type;

   typedef struct packed {
      logic signed [16:0] result_value;
      logic               thrust_limited;
      logic               power_zeroed;
   } qtpm_response_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P_SQUARE,
      ST_P_QTERM,
      ST_P_LTERM,
      ST_P_SUM,
      ST_P_ROUND,
      ST_T_LSQ,
      ST_T_QTERM,
      ST_T_DISC,
      ST_T_CHECK,
      ST_T_SQRT,
      ST_T_ROOT,
      ST_T_THRESH,
      ST_T_CMP,
      ST_T_SAT,
      ST_DIV,
      ST_DIV_FIN,
      ST_DONE
   } qtpm_state_type;

endpackage

// ===== hdl/quadratic_thrust_power_mapper_top.sv =====
// Quadratic thrust/power mapper: sequencer, shared multiplier, shared
// subtractor for square root and division, APB-style register port.
// Depends on qtpm_pkg and quadratic_thrust_power_mapper_top_defines.svh.
//
// Usage:
//   A request (req_data: req_type, operand_in) is taken when req_valid is
//   high and req_stall low. req_stall stays high while a request is being
//   worked on, so one request is in flight at a time. The response
//   (rsp_data: result_value, thrust_limited, power_zeroed) sits in an output
//   register and is taken when rsp_valid is high and rsp_stall low; the next
//   request may be accepted while it waits there.
//   Scale below maximum and the unused code go straight to ST_DONE; power
//   to thrust runs its products on the multiplier; scaling at or above the
//   maximum may run a division; thrust to power takes the most steps (up to
//   25 square root steps and 16 division steps on one subtractor, one multiplier for the products).
//   A new request can be accepted in the cycle after the response is loaded.
//   If the receiver stalls, a finished result waits in the sequencer until
//   the output register frees up; no response is dropped.
//   Coefficients are written on the csr_ port at byte addresses 0, 4, 8
//   and are read back sign-extended; write them only while idle.
//   Reset (synchronous, active high) sets C=0, L=0, Q=1.0 and empties
//   the pipeline.
`include "quadratic_thrust_power_mapper_top_defines.svh"

module quadratic_thrust_power_mapper_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  qtpm_pkg::qtpm_request_type   req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output qtpm_pkg::qtpm_response_type  rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   qtpm_pkg::qtpm_state_type    state_ff, state_in;
   logic signed [15:0]          coef_c_ff, coef_l_ff, coef_q_ff;
   logic                        neg_ff, neg_in;
   logic                        lim_ff, lim_in;
   logic                        zero_ff, zero_in;
   logic [16:0]                 mag_ff, mag_in;
   logic signed [18:0]          thr_ff, thr_in;
   logic signed [47:0]          acc_ff, acc_in;
   logic signed [50:0]          prod_ff;
   logic [49:0]                 rad_ff, rad_in;
   logic [33:0]                 rem_ff, rem_in;
   logic [24:0]                 root_ff, root_in;
   logic [15:0]                 quot_ff, quot_in;
   logic [31:0]                 dsh_ff, dsh_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic signed [26:0]          n_ff, n_in;
   logic [16:0]                 result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   qtpm_pkg::qtpm_response_type rsp_data_ff, rsp_data_in;

   logic signed [17:0] peak_thrust;
   logic signed [18:0] max19;
   logic [16:0]        req_mag;
   logic               req_neg;
   logic               mag_ge_max;
   logic               max_nonpos;
   qtpm_pkg::qtpm_op_type req_op;

   logic signed [31:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [50:0] mul_p;
   logic [33:0]        sub_a, sub_b;
   logic [34:0]        sub_diff;
   logic               sub_ge;
   logic signed [19:0] diff_ct;

   logic [47:0]        s_mag;
   logic [47:0]        round_sum;
   logic [17:0]        r_mag;
   logic               t_sign;
   logic [16:0]        p2t_value;
   logic [15:0]        quot_clamped;
   logic signed [50:0] thresh_rhs;
   logic               csr_write;

   logic               sqrt_more;
   logic               done_load;
   logic               zeroed_out;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_c_ff <= 16'sd0;
         coef_l_ff <= 16'sd0;
         coef_q_ff <= qtpm_pkg::SQUARE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            qtpm_pkg::REG_CONSTANT: coef_c_ff <= csr_pwdata[15:0];
            qtpm_pkg::REG_LINEAR:   coef_l_ff <= csr_pwdata[15:0];
            qtpm_pkg::REG_SQUARE:   coef_q_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         qtpm_pkg::REG_CONSTANT: csr_prdata = {{16{coef_c_ff[15]}}, coef_c_ff};
         qtpm_pkg::REG_LINEAR:   csr_prdata = {{16{coef_l_ff[15]}}, coef_l_ff};
         qtpm_pkg::REG_SQUARE:   csr_prdata = {{16{coef_q_ff[15]}}, coef_q_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // ---------------- request decode ----------------
   assign peak_thrust = {{2{coef_c_ff[15]}}, coef_c_ff} + {{2{coef_l_ff[15]}}, coef_l_ff}
                      + {{2{coef_q_ff[15]}}, coef_q_ff};
   assign max19      = {peak_thrust[17], peak_thrust};
   assign max_nonpos = peak_thrust[17] | (peak_thrust == 18'sd0);
   assign req_neg    = req_data.operand_in[15];
   assign req_mag    = req_neg ? 17'd0 - {req_data.operand_in[15], req_data.operand_in}
                               : {1'b0, req_data.operand_in};
   assign mag_ge_max = $signed({2'b00, req_mag}) >= max19;
   assign req_op     = qtpm_pkg::qtpm_op_type'(req_data.req_type);

   assign req_stall = (state_ff != qtpm_pkg::ST_IDLE);

   // ---------------- shared units ----------------
   assign diff_ct = {{4{coef_c_ff[15]}}, coef_c_ff} - {thr_ff[18], thr_ff};

   always_comb begin
      mul_a = 32'sd0;
      mul_b = 19'sd0;
      sub_a = 34'd0;
      sub_b = 34'd0;
      case (state_ff)
         qtpm_pkg::ST_P_SQUARE: begin
            mul_a = {15'd0, mag_ff};
            mul_b = {2'b00, mag_ff};
         end
         qtpm_pkg::ST_P_QTERM: begin
            mul_a = prod_ff[31:0];
            mul_b = {{3{coef_q_ff[15]}}, coef_q_ff};
         end
         qtpm_pkg::ST_P_LTERM: begin
            mul_a = {15'd0, mag_ff};
            mul_b = {{3{coef_l_ff[15]}}, coef_l_ff};
         end
         qtpm_pkg::ST_T_LSQ: begin
            mul_a = {{16{coef_l_ff[15]}}, coef_l_ff};
            mul_b = {{3{coef_l_ff[15]}}, coef_l_ff};
         end
         qtpm_pkg::ST_T_QTERM: begin
            mul_a = {{12{diff_ct[19]}}, diff_ct};
            mul_b = {{3{coef_q_ff[15]}}, coef_q_ff};
         end
         qtpm_pkg::ST_T_THRESH: begin
            mul_a = {{5{n_ff[26]}}, n_ff};
            mul_b = qtpm_pkg::THRESH_MUL;
         end
         qtpm_pkg::ST_T_SQRT: begin
            sub_a = {rem_ff[31:0], rad_ff[49:48]};
            sub_b = {7'd0, root_ff, 2'b01};
         end
         qtpm_pkg::ST_T_SAT: begin
            sub_a = rem_ff;
            sub_b = {3'd0, coef_q_ff[14:0], 16'd0};
         end
         qtpm_pkg::ST_DIV: begin
            sub_a = rem_ff;
            sub_b = {2'b00, dsh_ff};
         end
         default: ;
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = ~sub_diff[34];

   // ---------------- result shaping ----------------
   // Round |s| / 2^30 half away from zero, reapply sign, saturate.
   assign s_mag     = acc_ff[47] ? 48'd0 - acc_ff : acc_ff;
   assign round_sum = s_mag + 48'h0000_2000_0000;
   assign r_mag     = round_sum[47:30];
   assign t_sign    = acc_ff[47] ^ neg_ff;

   always_comb begin
      if (t_sign) begin
         p2t_value = (r_mag > 18'd32768) ? qtpm_pkg::RESULT_MINUS_ONE
                                         : 17'd0 - r_mag[16:0];
      end else begin
         p2t_value = (r_mag > 18'd32767) ? 17'h07FFF : {1'b0, r_mag[15:0]};
      end
   end

   assign quot_clamped = (quot_ff > qtpm_pkg::QUOT_CAP) ? qtpm_pkg::QUOT_CAP : quot_ff;
   assign thresh_rhs   = {{20{coef_q_ff[15]}}, coef_q_ff, 15'd0};

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      lim_in       = lim_ff;
      zero_in      = zero_ff;
      mag_in       = mag_ff;
      thr_in       = thr_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      quot_in      = quot_ff;
      dsh_in       = dsh_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         qtpm_pkg::ST_IDLE: begin
            if (req_valid) begin
               mag_in  = req_mag;
               neg_in  = req_neg;
               lim_in  = 1'b0;
               zero_in = 1'b0;
               case (req_op)
                  qtpm_pkg::OP_POWER_TO_THRUST: begin
                     state_in = qtpm_pkg::ST_P_SQUARE;
                  end
                  qtpm_pkg::OP_THRUST_TO_POWER: begin
                     // clamp magnitude to the maximum thrust
                     lim_in   = mag_ge_max;
                     thr_in   = mag_ge_max ? max19 : $signed({2'b00, req_mag});
                     state_in = qtpm_pkg::ST_T_LSQ;
                  end
                  qtpm_pkg::OP_SCALE: begin
                     neg_in = 1'b0;
                     if (!mag_ge_max) begin
                        result_in = qtpm_pkg::RESULT_ONE;
                        state_in  = qtpm_pkg::ST_DONE;
                     end else begin
                        lim_in = 1'b1;
                        if ((req_mag == 17'd0) || max_nonpos) begin
                           result_in = 17'd0;
                           state_in  = qtpm_pkg::ST_DONE;
                        end else begin
                           rem_in   = {2'b00, peak_thrust[16:0], 15'd0};
                           dsh_in   = {req_mag, 15'd0};
                           quot_in  = 16'd0;
                           cnt_in   = qtpm_pkg::DIV_LAST;
                           state_in = qtpm_pkg::ST_DIV;
                        end
                     end
                  end
                  default: begin
                     result_in = 17'd0;
                     state_in  = qtpm_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // power to thrust
         qtpm_pkg::ST_P_SQUARE: state_in = qtpm_pkg::ST_P_QTERM;
         qtpm_pkg::ST_P_QTERM:  state_in = qtpm_pkg::ST_P_LTERM;
         qtpm_pkg::ST_P_LTERM: begin
            acc_in   = $signed({{2{coef_c_ff[15]}}, coef_c_ff, 30'd0})
                     + $signed(prod_ff[47:0]);
            state_in = qtpm_pkg::ST_P_SUM;
         end
         qtpm_pkg::ST_P_SUM: begin
            acc_in   = acc_ff + $signed({prod_ff[32:0], 15'd0});
            state_in = qtpm_pkg::ST_P_ROUND;
         end
         qtpm_pkg::ST_P_ROUND: begin
            result_in = p2t_value;
            state_in  = qtpm_pkg::ST_DONE;
         end

         // thrust to power: discriminant
         qtpm_pkg::ST_T_LSQ: state_in = qtpm_pkg::ST_T_QTERM;
         qtpm_pkg::ST_T_QTERM: begin
            acc_in   = $signed(prod_ff[47:0]);
            state_in = qtpm_pkg::ST_T_DISC;
         end
         qtpm_pkg::ST_T_DISC: begin
            acc_in   = acc_ff - $signed({prod_ff[45:0], 2'b00});
            state_in = qtpm_pkg::ST_T_CHECK;
         end
         qtpm_pkg::ST_T_CHECK: begin
            if (coef_q_ff[15] || (coef_q_ff == 16'sd0) || acc_ff[47]) begin
               zero_in   = 1'b1;
               result_in = 17'd0;
               state_in  = qtpm_pkg::ST_DONE;
            end else begin
               rad_in   = {acc_ff[33:0], 16'd0};
               rem_in   = 34'd0;
               root_in  = 25'd0;
               cnt_in   = qtpm_pkg::SQRT_LAST;
               state_in = qtpm_pkg::ST_T_SQRT;
            end
         end

         // one root bit per cycle
         qtpm_pkg::ST_T_SQRT: begin
            if (sub_ge) begin
               rem_in  = sub_diff[33:0];
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in  = sub_a;
               root_in = {root_ff[23:0], 1'b0};
            end
            rad_in = {rad_ff[47:0], 2'b00};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = qtpm_pkg::ST_T_ROOT;
            end
         end
         qtpm_pkg::ST_T_ROOT: begin
            n_in     = $signed({2'b00, root_ff})
                     - $signed({{3{coef_l_ff[15]}}, coef_l_ff, 8'd0});
            state_in = qtpm_pkg::ST_T_THRESH;
         end
         qtpm_pkg::ST_T_THRESH: state_in = qtpm_pkg::ST_T_CMP;
         qtpm_pkg::ST_T_CMP: begin
            if (prod_ff < thresh_rhs) begin
               zero_in   = 1'b1;
               result_in = 17'd0;
               state_in  = qtpm_pkg::ST_DONE;
            end else begin
               // numerator n*64 + q/2, rounds the quotient half up
               rem_in   = {3'd0, n_ff[24:0], 6'd0} + {19'd0, coef_q_ff[15:1]};
               state_in = qtpm_pkg::ST_T_SAT;
            end
         end
         qtpm_pkg::ST_T_SAT: begin
            if (sub_ge) begin
               result_in = neg_ff ? qtpm_pkg::RESULT_MINUS_ONE : qtpm_pkg::RESULT_ONE;
               state_in  = qtpm_pkg::ST_DONE;
            end else begin
               dsh_in   = {2'b00, coef_q_ff[14:0], 15'd0};
               quot_in  = 16'd0;
               cnt_in   = qtpm_pkg::DIV_LAST;
               state_in = qtpm_pkg::ST_DIV;
            end
         end

         // one quotient bit per cycle
         qtpm_pkg::ST_DIV: begin
            if (sub_ge) begin
               rem_in  = sub_diff[33:0];
               quot_in = {quot_ff[14:0], 1'b1};
            end else begin
               quot_in = {quot_ff[14:0], 1'b0};
            end
            dsh_in = {1'b0, dsh_ff[31:1]};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = qtpm_pkg::ST_DIV_FIN;
            end
         end
         qtpm_pkg::ST_DIV_FIN: begin
            result_in = neg_ff ? 17'd0 - {1'b0, quot_clamped} : {1'b0, quot_clamped};
            state_in  = qtpm_pkg::ST_DONE;
         end

         qtpm_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.result_value   = $signed(result_ff);
               rsp_data_in.thrust_limited = lim_ff;
               rsp_data_in.power_zeroed   = zero_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = qtpm_pkg::ST_IDLE;
            end
         end

         default: state_in = qtpm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qtpm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      lim_ff      <= lim_in;
      zero_ff     <= zero_in;
      mag_ff      <= mag_in;
      thr_ff      <= thr_in;
      acc_ff      <= acc_in;
      prod_ff     <= mul_p;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      quot_ff     <= quot_in;
      dsh_ff      <= dsh_in;
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   assign sqrt_more  = (state_ff == qtpm_pkg::ST_T_SQRT) && (cnt_ff != 5'd0);
   assign done_load  = (state_ff == qtpm_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign zeroed_out = rsp_valid && rsp_data.power_zeroed;

   `QTPM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `QTPM_ASSERT_IMPLIES(a_zeroed_is_zero, clock, reset, zeroed_out, rsp_data.result_value == 17'sd0)

   `QTPM_ASSERT_NEXT(a_sqrt_runs, clock, reset, sqrt_more, state_ff == qtpm_pkg::ST_T_SQRT)

   `QTPM_ASSERT_NEXT(a_done_loads, clock, reset, done_load, rsp_valid_ff && !req_stall)

endmodule

// ===== test/quadratic_thrust_power_mapper_top_tb.sv =====
// Testbench for quadratic_thrust_power_mapper_top: bursty request driver, stalling
// response monitor and an in-bench mapping predictor checked field by field.
// Depends on qtpm_pkg and the RTL of quadratic_thrust_power_mapper_top.
`timescale 1ns / 1ps

module quadratic_thrust_power_mapper_top_tb;

   localparam int CYCLE_LIMIT   = 1500000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_ITEMS   = 130;
   localparam int RANDOM_PHASES = 9;
   // power threshold 0.01 as n*6400 < 32768*q
   localparam longint THRESH_NUM = 6400;
   localparam longint ONE_Q15    = 32768;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   qtpm_pkg::qtpm_request_type  req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   qtpm_pkg::qtpm_response_type rsp_data;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [3:0]                  csr_paddr = '0;
   logic [31:0]                 csr_pwdata = '0;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   // coefficient copies, Q8.8
   longint coef_c = 0;
   longint coef_l = 0;
   longint coef_q = 256;

   qtpm_pkg::qtpm_request_type  request_backlog[$];
   qtpm_pkg::qtpm_response_type predicted_mappings[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int settings_used = 1;
   int ops_seen[4] = '{0, 0, 0, 0};
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int stall_pct = 0;

   quadratic_thrust_power_mapper_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'h1 << 62;
      while (probe > v)
         probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic qtpm_pkg::qtpm_response_type map_request(qtpm_pkg::qtpm_request_type rq);
      qtpm_pkg::qtpm_response_type rs;
      longint x, mag, maxt, disc, numer, val, acc, accmag;
      longint unsigned disc_u;
      rs = '0;
      x = rq.operand_in;
      mag = (x < 0) ? -x : x;
      maxt = coef_c + coef_l + coef_q;
      val = 0;
      case (rq.req_type)
         qtpm_pkg::OP_THRUST_TO_POWER: begin
            // clamp to maximum thrust, then solve q*p^2 + l*p + (c - t) = 0
            if (mag >= maxt) begin
               rs.thrust_limited = 1'b1;
               mag = maxt;
            end
            disc = coef_l * coef_l - 4 * coef_q * (coef_c - mag);
            if (coef_q <= 0 || disc < 0) begin
               rs.power_zeroed = 1'b1;
            end else begin
               disc_u = disc;
               numer = -coef_l * 256 + longint'(root_floor(disc_u << 16));
               if (numer * THRESH_NUM < ONE_Q15 * coef_q) begin
                  rs.power_zeroed = 1'b1;
               end else begin
                  val = (numer * 64 + coef_q / 2) / coef_q;
                  if (val > ONE_Q15)
                     val = ONE_Q15;
                  if (x < 0)
                     val = -val;
               end
            end
         end
         qtpm_pkg::OP_POWER_TO_THRUST: begin
            acc = coef_c * 1073741824 + coef_l * mag * 32768 + coef_q * mag * mag;
            accmag = (acc < 0) ? -acc : acc;
            val = (accmag + 536870912) >>> 30;
            if (acc < 0)
               val = -val;
            if (x < 0)
               val = -val;
            if (val > 32767)
               val = 32767;
            if (val < -32768)
               val = -32768;
         end
         qtpm_pkg::OP_SCALE: begin
            if (mag < maxt) begin
               val = ONE_Q15;
            end else begin
               rs.thrust_limited = 1'b1;
               if (mag == 0 || maxt <= 0) begin
                  val = 0;
               end else begin
                  val = maxt * ONE_Q15 / mag;
                  if (val > ONE_Q15)
                     val = ONE_Q15;
               end
            end
         end
         default: val = 0;
      endcase
      rs.result_value = val[16:0];
      return rs;
   endfunction

   // Driver: load requests in bursts, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_mappings.push_back(map_request(req_data));
            ops_seen[req_data.req_type]++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= request_backlog.pop_front();
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response, stall in segments of varying density
   always @(posedge clock) begin
      qtpm_pkg::qtpm_response_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_mappings.size() == 0) begin
               $error("response with nothing expected: result_value %0d", rsp_data.result_value);
               mismatch_count++;
            end else begin
               want = predicted_mappings.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, got %0d",
                         want.result_value, rsp_data.result_value);
                  mismatch_count++;
               end
               if (rsp_data.thrust_limited !== want.thrust_limited) begin
                  $error("thrust_limited: expected %0b, got %0b",
                         want.thrust_limited, rsp_data.thrust_limited);
                  mismatch_count++;
               end
               if (rsp_data.power_zeroed !== want.power_zeroed) begin
                  $error("power_zeroed: expected %0b, got %0b",
                         want.power_zeroed, rsp_data.power_zeroed);
                  mismatch_count++;
               end
            end
         end
         if (stall_left == 0) begin
            stall_left = $urandom_range(4, 80);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 30;
               3:       stall_pct = 60;
               default: stall_pct = 85;
            endcase
         end
         stall_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("quadratic_thrust_power_mapper_top_tb: errors");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] index, input longint value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {{16{value[15]}}, value[15:0]};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // sign-extend to match the 16-bit register
   function automatic longint as_q88(longint value);
      logic signed [15:0] narrow;
      narrow = value[15:0];
      return narrow;
   endfunction

   task automatic drain();
      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || predicted_mappings.size() != 0)
         @(negedge clock);
   endtask

   task automatic load_coeffs(input longint c, input longint l, input longint q);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(qtpm_pkg::REG_CONSTANT, c);
      csr_write(qtpm_pkg::REG_LINEAR, l);
      csr_write(qtpm_pkg::REG_SQUARE, q);
      coef_c = as_q88(c);
      coef_l = as_q88(l);
      coef_q = as_q88(q);
      settings_used++;
      @(negedge clock);
   endtask

   task automatic add_request(input logic [1:0] op, input int value);
      qtpm_pkg::qtpm_request_type rq;
      rq.req_type = op;
      rq.operand_in = value[15:0];
      request_backlog.push_back(rq);
   endtask

   function automatic int pick_operand();
      longint maxt, v;
      maxt = coef_c + coef_l + coef_q;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $signed($urandom_range(0, 65535)) - 32768;
         4, 5: begin
            // straddle the maximum thrust
            v = maxt + $urandom_range(0, 64) - 32;
            if (v > 32767)
               v = 32767;
            if (v < -32768)
               v = -32768;
            if ($urandom_range(0, 1) == 1 && v > -32768)
               v = -v;
         end
         6, 7: begin
            v = $urandom_range(0, 512);
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
         8: begin
            case ($urandom_range(0, 3))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom_range(0, 8);
      endcase
      return int'(v);
   endfunction

   task automatic add_random(input int count);
      logic [1:0] op;
      repeat (count) begin
         case ($urandom_range(0, 19))
            0:                   op = qtpm_pkg::OP_UNUSED;
            1, 2, 3, 4, 5, 6:    op = qtpm_pkg::OP_POWER_TO_THRUST;
            7, 8, 9, 10, 11, 12: op = qtpm_pkg::OP_SCALE;
            default:             op = qtpm_pkg::OP_THRUST_TO_POWER;
         endcase
         add_request(op, pick_operand());
      end
   endtask

   initial begin
      longint c, l, q;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coefficients: maximum thrust is exactly 1.0
      add_request(qtpm_pkg::OP_POWER_TO_THRUST, 0);
      add_request(qtpm_pkg::OP_POWER_TO_THRUST, 32767);
      add_request(qtpm_pkg::OP_POWER_TO_THRUST, -32768);
      add_request(qtpm_pkg::OP_POWER_TO_THRUST, -1);
      add_request(qtpm_pkg::OP_POWER_TO_THRUST, 16384);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, 0);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, 1);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, 256);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, 32767);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, -32768);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, -100);
      add_request(qtpm_pkg::OP_SCALE, 0);
      add_request(qtpm_pkg::OP_SCALE, 255);
      add_request(qtpm_pkg::OP_SCALE, 256);
      add_request(qtpm_pkg::OP_SCALE, 32767);
      add_request(qtpm_pkg::OP_SCALE, -32768);
      add_request(qtpm_pkg::OP_SCALE, 300);
      add_request(qtpm_pkg::OP_UNUSED, 0);
      add_request(qtpm_pkg::OP_UNUSED, -1);
      add_random(PHASE_ITEMS);

      load_coeffs(0, 128, 2560);
      add_random(PHASE_ITEMS);
      load_coeffs(32767, 32767, 32767);
      add_random(PHASE_ITEMS);

      // negative square term and negative maximum
      load_coeffs(-32768, -32768, -32768);
      add_request(qtpm_pkg::OP_THRUST_TO_POWER, 0);
      add_request(qtpm_pkg::OP_SCALE, 0);
      add_request(qtpm_pkg::OP_SCALE, -32768);
      add_random(PHASE_ITEMS);

      load_coeffs(100, 200, 0);
      add_random(PHASE_ITEMS);
      load_coeffs(32767, -32768, 1);
      add_random(PHASE_ITEMS);
      load_coeffs(-256, 0, 512);
      add_random(PHASE_ITEMS);

      repeat (RANDOM_PHASES) begin
         if ($urandom_range(0, 2) == 0) begin
            c = $urandom_range(0, 65535);
            l = $urandom_range(0, 65535);
            q = $urandom_range(0, 65535);
         end else begin
            c = longint'($urandom_range(0, 512)) - 256;
            l = longint'($urandom_range(0, 4608)) - 512;
            q = $urandom_range(1, 8192);
         end
         load_coeffs(c, l, q);
         add_random(PHASE_ITEMS);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_mappings.size() != 0) begin
         $error("%0d responses never arrived", predicted_mappings.size());
         mismatch_count++;
      end
      $display("ran %0d thrust-to-power, %0d power-to-thrust, %0d scaling, %0d unused-code",
               ops_seen[qtpm_pkg::OP_THRUST_TO_POWER], ops_seen[qtpm_pkg::OP_POWER_TO_THRUST],
               ops_seen[qtpm_pkg::OP_SCALE], ops_seen[qtpm_pkg::OP_UNUSED]);
      $display("requests over %0d coefficient settings, %0d mismatches",
               settings_used, mismatch_count);
      if (mismatch_count == 0)
         $display("quadratic_thrust_power_mapper_top_tb: clean");
      else
         $display("quadratic_thrust_power_mapper_top_tb: errors");
      $finish;
   end

endmodule
